FILE: rtl/lir_pkg.sv
// Package for the linear interpolation resampler: widths, codes, request types
// and small helper functions shared by the sequencer, the MAC unit and the top level.
// Depends on nothing.
package lir_pkg;

    // Fixed sizes of the datapath.
    localparam int MAX_CHANNELS = 8;
    localparam int FRAC_BITS    = 20;
    localparam int SAMPLE_W     = 32;
    localparam int STEP_W       = 25;
    localparam int PHASE_W      = STEP_W + 1;
    localparam int COEF_W       = FRAC_BITS + 1;
    localparam int PROD_W       = SAMPLE_W + COEF_W + 1;
    localparam int CHAN_W       = $clog2(MAX_CHANNELS);
    localparam int CCNT_W       = 4;
    localparam int MAX_RESULTS  = 16;
    localparam int RES_CNT_W    = $clog2(MAX_RESULTS);
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = STEP_W;

    // One frame in fixed point, and the legal step range (1/16 to 16).
    localparam logic [PHASE_W-1:0] ONE_FRAC = PHASE_W'(64'd1 << FRAC_BITS);
    localparam logic [STEP_W-1:0]  STEP_MIN = STEP_W'(64'd1 << (FRAC_BITS - 4));
    localparam logic [STEP_W-1:0]  STEP_MAX = STEP_W'(64'd1 << (FRAC_BITS + 4));

    // Reset values of the configuration registers.
    localparam logic [CCNT_W-1:0] CHANNEL_COUNT_RST = CCNT_W'(2);
    localparam logic [1:0]        WIDTH_MODE_RST    = 2'd0;

    // Sample width codes; any other code means 32-bit samples.
    localparam logic [1:0] MODE_16 = 2'd0;
    localparam logic [1:0] MODE_24 = 2'd1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_COUNT = 2'd0,
        REG_WIDTH_MODE    = 2'd1,
        REG_STEP_RATIO    = 2'd2
    } cfg_reg_t;

    // Operations of the shared multiply-accumulate unit.
    typedef enum logic [1:0] {
        MAC_HOLD,
        MAC_FIRST,
        MAC_SECOND,
        MAC_FINAL
    } mac_op_t;

    // Input request: one frame of samples.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_0;
        logic signed [SAMPLE_W-1:0] sample_1;
        logic signed [SAMPLE_W-1:0] sample_2;
        logic signed [SAMPLE_W-1:0] sample_3;
        logic signed [SAMPLE_W-1:0] sample_4;
        logic signed [SAMPLE_W-1:0] sample_5;
        logic signed [SAMPLE_W-1:0] sample_6;
        logic signed [SAMPLE_W-1:0] sample_7;
    } in_frame_t;

    // Output request: one interpolated frame.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_0;
        logic signed [SAMPLE_W-1:0] out_1;
        logic signed [SAMPLE_W-1:0] out_2;
        logic signed [SAMPLE_W-1:0] out_3;
        logic signed [SAMPLE_W-1:0] out_4;
        logic signed [SAMPLE_W-1:0] out_5;
        logic signed [SAMPLE_W-1:0] out_6;
        logic signed [SAMPLE_W-1:0] out_7;
        logic                       last_of_run;
    } out_frame_t;

    // Controls from the sequencer to the datapath.
    typedef struct packed {
        mac_op_t             op;
        logic [CHAN_W-1:0]   chan;
        logic                use_cur;
        logic [COEF_W-1:0]   coef;
        logic                res_write;
        logic                emit;
        logic                last;
        logic                frame_done;
    } seq_ctl_t;

    // Keep the low sample-width bits and sign-extend them to 32 bits.
    function automatic logic [SAMPLE_W-1:0] sext_sample(input logic [SAMPLE_W-1:0] v,
                                                        input logic [1:0] mode);
        logic [SAMPLE_W-1:0] r;
        case (mode)
            MODE_16: r = {{16{v[15]}}, v[15:0]};
            MODE_24: r = {{8{v[23]}}, v[23:0]};
            default: r = v;
        endcase
        return r;
    endfunction

    // Index of the highest active channel; zero acts as one channel.
    function automatic logic [CHAN_W-1:0] last_channel(input logic [CCNT_W-1:0] cc);
        logic [CHAN_W-1:0] r;
        if (cc == '0)
            r = '0;
        else if (cc > CCNT_W'(MAX_CHANNELS))
            r = CHAN_W'(MAX_CHANNELS - 1);
        else
            r = CHAN_W'(cc - 1'b1);
        return r;
    endfunction

    // Saturate the step to its legal range.
    function automatic logic [STEP_W-1:0] clamp_step(input logic [STEP_W-1:0] s);
        logic [STEP_W-1:0] r;
        if (s < STEP_MIN)
            r = STEP_MIN;
        else if (s > STEP_MAX)
            r = STEP_MAX;
        else
            r = s;
        return r;
    endfunction

endpackage

FILE: rtl/lir_mac.sv
// Shared multiply-accumulate unit of the resampler: one signed sample by an
// unsigned Q20 weight per MAC_FIRST/MAC_SECOND cycle, shift by the
// fraction width, and a two-term sum. Depends on lir_pkg.
module lir_mac (
    input  logic                           clk,
    input  lir_pkg::mac_op_t               op,
    input  logic signed [lir_pkg::SAMPLE_W-1:0] a,
    input  logic [lir_pkg::COEF_W-1:0]     b,
    output logic [lir_pkg::SAMPLE_W-1:0]   sum
);
    import lir_pkg::*;

    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic [SAMPLE_W-1:0]        acc_reg;
    logic [SAMPLE_W-1:0]        term;

    // Product of the sample and the zero-extended weight.
    assign prod_next = a * $signed({1'b0, b});

    // Arithmetic shift right by the fraction width; only the low sample bits
    // matter since the sum wraps to the sample width.
    assign term = prod_reg[FRAC_BITS +: SAMPLE_W];

    // Both weighted terms added together.
    assign sum = acc_reg + term;

    // Product register and partial sum.
    always_ff @(posedge clk)
    begin
        case (op)
            MAC_FIRST:
            begin
                prod_reg <= prod_next;
            end
            MAC_SECOND:
            begin
                acc_reg  <= term;
                prod_reg <= prod_next;
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: rtl/lir_seq.sv
// Sequencer of the resampler: walks the outputs of one input frame and the
// channels of each output, drives the shared MAC unit and keeps the phase.
// Depends on lir_pkg.
module lir_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        out_free,
    input  logic [lir_pkg::STEP_W-1:0]  step,
    input  logic [lir_pkg::CHAN_W-1:0]  last_chan,
    output logic                        ready,
    output lir_pkg::seq_ctl_t           ctl
);
    import lir_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_MUL_PREV,
        ST_MUL_CUR,
        ST_SUM,
        ST_EMIT,
        ST_FINISH
    } state_t;

    state_t                 state_reg;
    logic [STEP_W-1:0]      phase_reg;
    logic [PHASE_W-1:0]     work_reg;
    logic [CHAN_W-1:0]      chan_reg;
    logic [RES_CNT_W-1:0]   count_reg;

    logic [FRAC_BITS-1:0]   frac;
    logic                   frac_zero;
    logic [COEF_W-1:0]      coef_prev;
    logic [COEF_W-1:0]      coef_cur;
    logic [PHASE_W-1:0]     work_adv;
    logic                   is_last;
    logic [STEP_W-1:0]      phase_done;

    // Weights of the two neighbors; a zero fraction selects the current sample.
    assign frac      = work_reg[FRAC_BITS-1:0];
    assign frac_zero = (frac == '0);
    assign coef_prev = frac_zero ? '0 : COEF_W'(ONE_FRAC) - {1'b0, frac};
    assign coef_cur  = frac_zero ? COEF_W'(ONE_FRAC) : {1'b0, frac};

    // Position of the next output and whether this output closes the run.
    assign work_adv = work_reg + {1'b0, step};
    assign is_last  = (work_adv > ONE_FRAC) || (count_reg == RES_CNT_W'(MAX_RESULTS - 1));

    // Phase carried to the next frame, never below one.
    assign phase_done = (work_reg > ONE_FRAC) ? STEP_W'(work_reg - ONE_FRAC) : STEP_W'(1);

    assign ready = (state_reg == ST_IDLE);

    // Datapath controls decoded from the state.
    always_comb
    begin
        ctl            = '0;
        ctl.op         = MAC_HOLD;
        ctl.chan       = chan_reg;
        ctl.use_cur    = (state_reg == ST_MUL_CUR);
        ctl.coef       = (state_reg == ST_MUL_PREV) ? coef_prev : coef_cur;
        ctl.last       = is_last;
        case (state_reg)
            ST_MUL_PREV: ctl.op = MAC_FIRST;
            ST_MUL_CUR:  ctl.op = MAC_SECOND;
            ST_SUM:
            begin
                ctl.op        = MAC_FINAL;
                ctl.res_write = 1'b1;
            end
            ST_EMIT:     ctl.emit = out_free;
            ST_FINISH:   ctl.frame_done = 1'b1;
            default:
            begin
            end
        endcase
    end

    // State, phase and loop counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= STEP_W'(ONE_FRAC);
            work_reg  <= '0;
            chan_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        work_reg  <= {1'b0, phase_reg};
                        count_reg <= '0;
                        state_reg <= ST_START;
                    end
                end
                ST_START:
                begin
                    chan_reg <= '0;
                    if (work_reg > ONE_FRAC)
                        state_reg <= ST_FINISH;
                    else
                        state_reg <= ST_MUL_PREV;
                end
                ST_MUL_PREV:
                begin
                    state_reg <= ST_MUL_CUR;
                end
                ST_MUL_CUR:
                begin
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    if (chan_reg == last_chan)
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        chan_reg  <= chan_reg + 1'b1;
                        state_reg <= ST_MUL_PREV;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        work_reg  <= work_adv;
                        count_reg <= count_reg + 1'b1;
                        chan_reg  <= '0;
                        state_reg <= is_last ? ST_FINISH : ST_MUL_PREV;
                    end
                end
                ST_FINISH:
                begin
                    phase_reg <= phase_done;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // The stored phase is at least one fraction step.
    a_phase_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != '0)
        else $error("phase register reached zero");

    // An accepted frame makes the block busy in the next cycle.
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !ready)
        else $error("block still ready after accepting a frame");

    // A result is only loaded into a free output slot.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> out_free)
        else $error("result loaded over a waiting result");

    // Partial results are never written beyond the active channels.
    a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.res_write |-> (ctl.chan <= last_chan))
        else $error("channel write beyond the active channels");
`endif

endmodule

FILE: rtl/linear_interp_resampler.sv
// Top level of the linear interpolation resampler: configuration registers,
// frame storage, result and output registers around the sequencer and MAC unit.
// Depends on lir_pkg, lir_mac and lir_seq.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one frame of eight samples
//   per request. Output channel (out_valid/out_ready/out_data) gives zero to
//   sixteen interpolated frames per input request; last_of_run marks the final
//   one of each run. Configuration is written through cfg_write/cfg_index/
//   cfg_data while the block is idle: channel count, sample width, step ratio.
// Operation:
//   One shared multiplier serves every product. For each active channel the
//   sequencer steps through ST_MUL_PREV, ST_MUL_CUR and ST_SUM; each output
//   then waits in ST_EMIT while the output register is full. A frame opens
//   with ST_START and closes with ST_FINISH; output stalls lengthen it.
//   in_ready is high only while no frame is in work.
// Reset and stalls:
//   Reset clears the stored previous frame, sets the phase to one frame and
//   loads the register defaults. A finished result waits in the output
//   register; while it is not taken, the sequencer holds before loading the
//   next result. The last result of a frame may wait while a new frame enters.
module linear_interp_resampler (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  lir_pkg::in_frame_t                in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output lir_pkg::out_frame_t               out_data,
    input  logic                              cfg_write,
    input  logic [lir_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lir_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import lir_pkg::*;

    logic [CCNT_W-1:0]      channel_count_reg;
    logic [1:0]             width_mode_reg;
    logic [STEP_W-1:0]      step_ratio_reg;

    logic [SAMPLE_W-1:0]    cur_reg  [MAX_CHANNELS];
    logic [SAMPLE_W-1:0]    prev_reg [MAX_CHANNELS];
    logic [SAMPLE_W-1:0]    res_reg  [MAX_CHANNELS];
    logic [SAMPLE_W-1:0]    in_samples [MAX_CHANNELS];
    logic [SAMPLE_W-1:0]    res_masked [MAX_CHANNELS];

    logic                   out_valid_reg;
    out_frame_t             out_data_reg;
    out_frame_t             out_next;

    logic                   start;
    logic                   seq_ready;
    logic                   out_free;
    logic [STEP_W-1:0]      step_eff;
    logic [CHAN_W-1:0]      last_chan;
    seq_ctl_t               ctl;
    logic [SAMPLE_W-1:0]    mac_a;
    logic [SAMPLE_W-1:0]    mac_sum;

    // Handshake and effective configuration.
    assign in_ready  = seq_ready;
    assign start     = in_valid && seq_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign step_eff  = clamp_step(step_ratio_reg);
    assign last_chan = last_channel(channel_count_reg);

    // Input frame as an array of channels.
    always_comb
    begin
        in_samples[0] = in_data.sample_0;
        in_samples[1] = in_data.sample_1;
        in_samples[2] = in_data.sample_2;
        in_samples[3] = in_data.sample_3;
        in_samples[4] = in_data.sample_4;
        in_samples[5] = in_data.sample_5;
        in_samples[6] = in_data.sample_6;
        in_samples[7] = in_data.sample_7;
    end

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= CHANNEL_COUNT_RST;
            width_mode_reg    <= WIDTH_MODE_RST;
            step_ratio_reg    <= STEP_W'(ONE_FRAC);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[CCNT_W-1:0];
                REG_WIDTH_MODE:    width_mode_reg    <= cfg_data[1:0];
                REG_STEP_RATIO:    step_ratio_reg    <= cfg_data[STEP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Current frame is captured on each request.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int k = 0; k < MAX_CHANNELS; k++)
                cur_reg[k] <= in_samples[k];
        end
    end

    // Previous frame takes over the current one when a frame is done.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_CHANNELS; k++)
                prev_reg[k] <= '0;
        end
        else if (ctl.frame_done)
        begin
            for (int k = 0; k < MAX_CHANNELS; k++)
                prev_reg[k] <= cur_reg[k];
        end
    end

    // Operand select for the shared unit, sign-extended from the sample width.
    assign mac_a = sext_sample(ctl.use_cur ? cur_reg[ctl.chan] : prev_reg[ctl.chan],
                               width_mode_reg);

    lir_mac u_mac (
        .clk (clk),
        .op  (ctl.op),
        .a   (mac_a),
        .b   (ctl.coef),
        .sum (mac_sum)
    );

    lir_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .out_free  (out_free),
        .step      (step_eff),
        .last_chan (last_chan),
        .ready     (seq_ready),
        .ctl       (ctl)
    );

    // Per-channel results, wrapped to the sample width.
    always_ff @(posedge clk)
    begin
        if (ctl.res_write)
            res_reg[ctl.chan] <= sext_sample(mac_sum, width_mode_reg);
    end

    // Inactive channels read as zero.
    always_comb
    begin
        for (int k = 0; k < MAX_CHANNELS; k++)
            res_masked[k] = (CHAN_W'(k) <= last_chan) ? res_reg[k] : '0;
        out_next.out_0       = res_masked[0];
        out_next.out_1       = res_masked[1];
        out_next.out_2       = res_masked[2];
        out_next.out_3       = res_masked[3];
        out_next.out_4       = res_masked[4];
        out_next.out_5       = res_masked[5];
        out_next.out_6       = res_masked[6];
        out_next.out_7       = res_masked[7];
        out_next.last_of_run = ctl.last;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
            out_data_reg <= out_next;
    end

endmodule

FILE: tb/tb_linear_interp_resampler.sv
// Self-checking testbench for linear_interp_resampler: frames go in and interpolated frames
// come out over valid/ready, and a scoreboard class predicts and checks every output.
// Depends on lir_pkg and the linear_interp_resampler RTL.
module tb_linear_interp_resampler;

    timeunit 1ns;
    timeprecision 1ps;

    // Fixed-point unit and the legal step range.
    localparam longint UNIT_Q20 = 64'sd1 <<< lir_pkg::FRAC_BITS;
    localparam longint STEP_LO  = UNIT_Q20 >>> 4;
    localparam longint STEP_HI  = UNIT_Q20 <<< 4;

    // Width codes for 32-bit samples (code three behaves like code two).
    localparam logic [1:0] MODE_32     = 2'd2;
    localparam logic [1:0] MODE_32_ALT = 2'd3;

    // Register index that is not mapped to any register.
    localparam logic [lir_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 32;
    localparam int TAIL_CYCLES    = 64;
    localparam int HOLD_CYCLES    = 300;
    localparam int REPORT_CAP     = 100;
    localparam int RANDOM_ITEMS   = 90;

    // Predicts the interpolated frames for each accepted request and checks
    // the output requests against them in order.
    class interp_scoreboard;
        logic [lir_pkg::CCNT_W-1:0]   chan_count;
        logic [1:0]                   width_mode;
        logic [lir_pkg::STEP_W-1:0]   step_q20;
        logic [lir_pkg::SAMPLE_W-1:0] held_frame [lir_pkg::MAX_CHANNELS];
        logic [lir_pkg::STEP_W-1:0]   out_phase;
        lir_pkg::out_frame_t          due_outputs [$];
        int                           mismatches;

        function new();
            chan_count = lir_pkg::CHANNEL_COUNT_RST;
            width_mode = lir_pkg::WIDTH_MODE_RST;
            step_q20   = lir_pkg::STEP_W'(UNIT_Q20);
            out_phase  = lir_pkg::STEP_W'(UNIT_Q20);
            foreach (held_frame[c])
                held_frame[c] = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return due_outputs.size();
        endfunction

        // Register writes; unmapped indexes are ignored.
        function void write_register(logic [lir_pkg::CFG_IDX_W-1:0] idx,
                                     logic [lir_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                lir_pkg::REG_CHANNEL_COUNT: chan_count = val[lir_pkg::CCNT_W-1:0];
                lir_pkg::REG_WIDTH_MODE:    width_mode = val[1:0];
                lir_pkg::REG_STEP_RATIO:    step_q20 = val;
                default: ;
            endcase
        endfunction

        function int sample_bits();
            if (width_mode == lir_pkg::MODE_16)
                return 16;
            if (width_mode == lir_pkg::MODE_24)
                return 24;
            return 32;
        endfunction

        // Sign-extend the low sample-width bits.
        function longint widen(logic [31:0] v, int width_bits);
            longint r;
            case (width_bits)
                16: r = $signed(v[15:0]);
                24: r = $signed(v[23:0]);
                default: r = $signed(v);
            endcase
            return r;
        endfunction

        // Wrap a sum to the sample width and sign-extend it to 32 bits.
        function logic [31:0] fold(longint v, int width_bits);
            logic [63:0] u;
            u = v;
            case (width_bits)
                16: return {{16{u[15]}}, u[15:0]};
                24: return {{8{u[23]}}, u[23:0]};
                default: return u[31:0];
            endcase
        endfunction

        // Work out every output that the new frame causes and queue them.
        function void predict_outputs(lir_pkg::in_frame_t frm);
            logic [31:0]         raw [8];
            longint              now_s [8];
            longint              old_s [8];
            lir_pkg::out_frame_t batch [$];
            lir_pkg::out_frame_t res;
            longint              pos, adv, frac, mix;
            int                  width_bits, active;
            width_bits = sample_bits();
            if (chan_count == 0)
                active = 1;
            else if (chan_count > lir_pkg::MAX_CHANNELS)
                active = lir_pkg::MAX_CHANNELS;
            else
                active = int'(chan_count);
            adv = step_q20;
            if (adv < STEP_LO)
                adv = STEP_LO;
            if (adv > STEP_HI)
                adv = STEP_HI;
            for (int c = 0; c < 8; c++) begin
                raw[c]   = frm[(7 - c) * 32 +: 32];
                now_s[c] = widen(raw[c], width_bits);
                old_s[c] = widen(held_frame[c], width_bits);
            end

            // One output per position that falls inside this frame interval, up to MAX_RESULTS.
            pos = out_phase;
            while (pos <= UNIT_Q20 && batch.size() < lir_pkg::MAX_RESULTS) begin
                frac = pos & (UNIT_Q20 - 1);
                res = '0;
                for (int c = 0; c < active; c++) begin
                    if (frac == 0)
                        mix = now_s[c];
                    else
                        mix = ((old_s[c] * (UNIT_Q20 - frac)) >>> lir_pkg::FRAC_BITS)
                            + ((now_s[c] * frac) >>> lir_pkg::FRAC_BITS);
                    res[(7 - c) * 32 + 1 +: 32] = fold(mix, width_bits);
                end
                batch.push_back(res);
                pos += adv;
            end
            if (batch.size() > 0) begin
                res = batch.pop_back();
                res.last_of_run = 1'b1;
                batch.push_back(res);
            end
            foreach (batch[i])
                due_outputs.push_back(batch[i]);

            // The phase never drops below one fractional step.
            pos -= UNIT_Q20;
            if (pos < 1)
                pos = 1;
            out_phase = pos[lir_pkg::STEP_W-1:0];
            for (int c = 0; c < 8; c++)
                held_frame[c] = raw[c];
        endfunction

        // Compare one output request with the oldest prediction, field by field.
        function void check_output(lir_pkg::out_frame_t got);
            lir_pkg::out_frame_t want;
            logic [31:0]         w, g;
            if (due_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t ns: unexpected output request, expected none, got %h",
                             $time, got);
                return;
            end
            want = due_outputs.pop_front();
            for (int c = 0; c < 8; c++) begin
                w = want[(7 - c) * 32 + 1 +: 32];
                g = got[(7 - c) * 32 + 1 +: 32];
                if (g !== w) begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP)
                        $display("%0t ns: out_%0d expected %h, got %h", $time, c, w, g);
                end
            end
            if (got.last_of_run !== want.last_of_run) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t ns: last_of_run expected %b, got %b",
                             $time, want.last_of_run, got.last_of_run);
            end
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_ready;
    lir_pkg::in_frame_t                in_data;
    logic                              out_valid;
    logic                              out_ready;
    lir_pkg::out_frame_t               out_data;
    logic                              cfg_write;
    logic [lir_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [lir_pkg::CFG_DATA_W-1:0]    cfg_data;

    interp_scoreboard sb = new();

    // Idling controls for the stimulus and the receiver, and the watchdog's idle counter.
    bit tx_fast;
    bit rx_fast;
    int hold_len;
    int idle_cycles;

    linear_interp_resampler u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Observe register writes and both handshakes at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (cfg_write)
                sb.write_register(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.predict_outputs(in_data);
            if (out_valid && out_ready)
                sb.check_output(out_data);
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("linear_interp_resampler verification failed");
            $finish;
        end
    end

    // Receiver: a random pause before each output request, none in fast mode, or a long hold when asked.
    initial
    begin : rx_side
        int pause;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (hold_len > 0) begin
                pause = hold_len;
                hold_len = 0;
            end
            else if (rx_fast)
                pause = 0;
            else
                pause = $urandom_range(0, 10);
            if (pause > 0) begin
                out_ready <= 1'b0;
                repeat (pause) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    function automatic logic [31:0] extreme_value(int unsigned sel);
        case (sel)
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_7FFF;
            3: return 32'hFFFF_8000;
            4: return 32'h5A7F_FFFF;
            5: return 32'hA580_0000;
            6: return 32'hFFFF_FFFF;
            7: return 32'h0000_0000;
            default: return 32'h0000_0001;
        endcase
    endfunction

    function automatic lir_pkg::in_frame_t fill_frame(logic [31:0] v);
        lir_pkg::in_frame_t frm;
        for (int c = 0; c < 8; c++)
            frm[(7 - c) * 32 +: 32] = v;
        return frm;
    endfunction

    // Mostly full-range random samples, with extremes mixed in.
    function automatic lir_pkg::in_frame_t random_frame();
        lir_pkg::in_frame_t frm;
        for (int c = 0; c < 8; c++) begin
            if ($urandom_range(0, 3) == 0)
                frm[(7 - c) * 32 +: 32] = extreme_value($urandom_range(0, 8));
            else
                frm[(7 - c) * 32 +: 32] = $urandom;
        end
        return frm;
    endfunction

    // Offer one input request; starts and ends at a falling edge.
    task automatic send_frame(lir_pkg::in_frame_t frm);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  <= frm;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [lir_pkg::CFG_IDX_W-1:0] idx,
                             logic [lir_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Stop offering requests until every predicted output has arrived, then
    // give a frame without outputs time to finish.
    task automatic wait_for_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write all three registers while idle; unused upper data bits carry noise.
    task automatic apply_config(logic [lir_pkg::CCNT_W-1:0] cc, logic [1:0] md,
                                logic [lir_pkg::STEP_W-1:0] stp);
        logic [31:0] junk;
        wait_for_idle();
        junk = $urandom;
        write_reg(lir_pkg::REG_CHANNEL_COUNT, {junk[lir_pkg::CFG_DATA_W-1:lir_pkg::CCNT_W], cc});
        junk = $urandom;
        write_reg(lir_pkg::REG_WIDTH_MODE, {junk[lir_pkg::CFG_DATA_W-1:2], md});
        write_reg(lir_pkg::REG_STEP_RATIO, stp);
    endtask

    initial
    begin : stimulus
        int                         sent;
        int                         burst;
        int                         pick;
        logic [lir_pkg::CCNT_W-1:0] cc;
        logic [1:0]                 md;
        logic [lir_pkg::STEP_W-1:0] stp;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        tx_fast   = 1'b0;
        rx_fast   = 1'b0;
        hold_len  = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: two 16-bit channels, unit step: each frame gives its own samples back.
        send_frame(fill_frame(32'h0000_7FFF));
        send_frame(fill_frame(32'hFFFF_8000));
        send_frame(fill_frame(32'hA5A5_7FFF));

        // Full-scale swings between the two 32-bit extremes at a fractional step.
        apply_config(4'd8, MODE_32, 25'h0C_0000);
        send_frame(fill_frame(32'h7FFF_FFFF));
        send_frame(fill_frame(32'h8000_0000));
        send_frame(fill_frame(32'h7FFF_FFFF));
        send_frame(fill_frame(32'h8000_0000));
        send_frame(random_frame());

        // Zero channels acts as one; smallest step gives up to sixteen outputs per frame.
        apply_config(4'd0, lir_pkg::MODE_24, lir_pkg::STEP_MIN);
        send_frame(fill_frame(32'h5A7F_FFFF));
        send_frame(fill_frame(32'hA580_0000));

        // Too many channels, width code three, and a step below the minimum.
        apply_config(4'd15, MODE_32_ALT, 25'h00_0001);
        send_frame(random_frame());
        send_frame(random_frame());

        // Largest step: most frames give no output.
        apply_config(4'd5, lir_pkg::MODE_16, lir_pkg::STEP_MAX);
        repeat (4) send_frame(random_frame());

        // Step above the maximum, and a write to an unmapped index.
        apply_config(4'd3, MODE_32, 25'h1FF_FFFF);
        write_reg(REG_NONE, lir_pkg::CFG_DATA_W'($urandom));
        repeat (3) send_frame(random_frame());

        // Zero step is raised to the minimum.
        apply_config(4'd8, lir_pkg::MODE_24, 25'h00_0000);
        repeat (2) send_frame(random_frame());

        // Receiver holds off while frames keep coming, so the block backs up.
        apply_config(4'd8, MODE_32, 25'h04_0000);
        hold_len = HOLD_CYCLES;
        tx_fast  = 1'b1;
        repeat (6) send_frame(random_frame());
        tx_fast = 1'b0;
        wait_for_idle();

        // Random phases, each with its own settings and idling style.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) == 0)
                cc = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
            else
                cc = 4'($urandom_range(1, 8));
            md = 2'($urandom_range(0, 3));
            pick = $urandom_range(0, 9);
            if (pick <= 5)
                stp = 25'($urandom_range(32'h1_0000, 32'h20_0000));
            else if (pick <= 7)
                stp = 25'($urandom_range(32'h20_0000, 32'h100_0000));
            else if (pick == 8)
                stp = 25'($urandom);
            else
                stp = 25'($urandom_range(1, 32) * 32'h1_0000);
            apply_config(cc, md, stp);
            tx_fast = ($urandom_range(0, 3) == 0);
            rx_fast = ($urandom_range(0, 3) == 0);
            burst = $urandom_range(5, 20);
            repeat (burst) send_frame(random_frame());
            sent += burst;
        end
        tx_fast = 1'b0;
        rx_fast = 1'b0;

        wait_for_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("linear_interp_resampler verification clean");
        else
            $display("linear_interp_resampler verification failed");
        $finish;
    end

endmodule
